[design/lexicographic_permutation_generator_macros.svh]
// Assertion helpers for the permutation generator.
`ifndef LEXICOGRAPHIC_PERMUTATION_GENERATOR_MACROS_SVH
`define LEXICOGRAPHIC_PERMUTATION_GENERATOR_MACROS_SVH

// Concurrent check on clk, suppressed while reset is held.
`define LPG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same check, also evaluated during reset.
`define LPG_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/lpg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package lpg_pkg;

	localparam int ELEM_W = 4;
	localparam int POS_W  = 3;
	localparam int CFG_W  = 4;
	localparam logic [CFG_W-1:0] PERM_LENGTH_RST = 4'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXH,
		ST_SCAN,
		ST_EMIT,
		ST_FIND,
		ST_SWAP_I,
		ST_SWAP_J,
		ST_REV_RD,
		ST_REV_LO,
		ST_REV_HI
	} st_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_EXH,
		OP_SCAN,
		OP_EMIT,
		OP_FIND,
		OP_SWAP_I,
		OP_SWAP_J,
		OP_REV_RD,
		OP_REV_LO,
		OP_REV_HI
	} op_t;

	typedef struct packed {
		op_t  op;
		logic restart;
	} cmd_t;

	typedef struct packed {
		logic done;      // enumeration exhausted
		logic found;     // pivot found in last scan
		logic scan_end;  // scan finishes this cycle
		logic emit_last; // emitting final element
		logic find_hit;  // swap partner found this cycle
		logic rev_more;  // reverse window not yet closed
		logic out_free;  // output register can take a word
	} sts_t;

endpackage
`default_nettype wire

[design/lpg_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module lpg_datapath import lpg_pkg::*; #(
	parameter int MAX_LENGTH = 8
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_we,
	input  wire [CFG_W-1:0]    cfg_wdata,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  wire                out_ready,
	output logic               out_valid,
	output logic [ELEM_W-1:0]  element,
	output logic [POS_W-1:0]   position,
	output logic               last_of_perm,
	output logic               final_perm,
	output logic               exhausted
);

	localparam int IW = $clog2(MAX_LENGTH);

	function automatic logic [IW-1:0] last_idx_of(input logic [CFG_W-1:0] v);
		logic [CFG_W-1:0] l;
		l = v;
		if (l == '0)
			l = CFG_W'(1);
		if (l > CFG_W'(MAX_LENGTH))
			l = CFG_W'(MAX_LENGTH);
		return IW'(l - CFG_W'(1));
	endfunction

	logic [ELEM_W-1:0] perm_q [MAX_LENGTH];
	logic [IW-1:0]     last_idx_q;
	logic [IW-1:0]     idx_q;
	logic [IW-1:0]     lo_q;
	logic [IW-1:0]     piv_q;
	logic [ELEM_W-1:0] pivval_q;
	logic [ELEM_W-1:0] tmp_q;
	logic              found_q;
	logic              done_q;

	logic              out_valid_q;
	logic [ELEM_W-1:0] elem_q;
	logic [POS_W-1:0]  pos_q;
	logic              last_q;
	logic              final_q;
	logic              exh_q;

	logic [IW-1:0]     rd_idx;
	logic [ELEM_W-1:0] rd_val;
	logic              wr_en;
	logic [IW-1:0]     wr_idx;
	logic [ELEM_W-1:0] wr_val;
	logic              load_id;
	logic              scan_first;
	logic              scan_hit;
	logic              out_load;

	// single read port
	always_comb begin
		case (cmd.op)
			OP_EMIT, OP_REV_RD: rd_idx = lo_q;
			default:            rd_idx = idx_q;
		endcase
	end
	assign rd_val = perm_q[rd_idx];

	assign scan_first = (idx_q == last_idx_q);
	assign scan_hit   = !scan_first && (rd_val < tmp_q);

	// single write port
	always_comb begin
		wr_en  = 1'b0;
		wr_idx = idx_q;
		wr_val = rd_val;
		case (cmd.op)
			OP_SWAP_I: begin
				wr_en  = 1'b1;
				wr_idx = piv_q;
			end
			OP_SWAP_J: begin
				wr_en  = 1'b1;
				wr_val = pivval_q;
			end
			OP_REV_LO: begin
				wr_en  = 1'b1;
				wr_idx = lo_q;
			end
			OP_REV_HI: begin
				wr_en  = 1'b1;
				wr_val = tmp_q;
			end
			default: wr_en = 1'b0;
		endcase
	end

	assign load_id  = cfg_we || (cmd.op == OP_LOAD && cmd.restart);
	assign out_load = (cmd.op == OP_EMIT) || (cmd.op == OP_EXH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_LENGTH; k++)
				perm_q[k] <= ELEM_W'(k + 1);
		end else if (load_id) begin
			for (int k = 0; k < MAX_LENGTH; k++)
				perm_q[k] <= ELEM_W'(k + 1);
		end else if (wr_en) begin
			perm_q[wr_idx] <= wr_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_idx_q <= last_idx_of(PERM_LENGTH_RST);
			done_q     <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			if (cfg_we)
				last_idx_q <= last_idx_of(cfg_wdata);
			if (load_id)
				done_q <= 1'b0;
			else if (cmd.op == OP_EMIT && lo_q == last_idx_q && !found_q)
				done_q <= 1'b1;
			if (cmd.op == OP_LOAD)
				found_q <= 1'b0;
			else if (cmd.op == OP_SCAN && scan_hit)
				found_q <= 1'b1;
		end
	end

	// walk registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				idx_q <= last_idx_q;
				lo_q  <= '0;
			end
			OP_SCAN: begin
				if (scan_hit) begin
					piv_q    <= idx_q;
					pivval_q <= rd_val;
				end else begin
					tmp_q <= rd_val;
					if (idx_q != '0)
						idx_q <= idx_q - IW'(1);
				end
			end
			OP_EMIT: begin
				if (lo_q != last_idx_q)
					lo_q <= lo_q + IW'(1);
				else
					idx_q <= last_idx_q;
			end
			OP_FIND: begin
				if (rd_val <= pivval_q)
					idx_q <= idx_q - IW'(1);
			end
			OP_SWAP_J: begin
				lo_q  <= piv_q + IW'(1);
				idx_q <= last_idx_q;
			end
			OP_REV_RD: tmp_q <= rd_val;
			OP_REV_HI: begin
				lo_q  <= lo_q + IW'(1);
				idx_q <= idx_q - IW'(1);
			end
			default: tmp_q <= tmp_q;
		endcase
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT) begin
			elem_q  <= rd_val;
			pos_q   <= POS_W'(lo_q);
			last_q  <= (lo_q == last_idx_q);
			final_q <= !found_q;
			exh_q   <= 1'b0;
		end else if (cmd.op == OP_EXH) begin
			elem_q  <= '0;
			pos_q   <= '0;
			last_q  <= 1'b0;
			final_q <= 1'b0;
			exh_q   <= 1'b1;
		end
	end

	assign sts.done      = done_q;
	assign sts.found     = found_q;
	assign sts.scan_end  = scan_hit || (idx_q == '0);
	assign sts.emit_last = (lo_q == last_idx_q);
	assign sts.find_hit  = (rd_val > pivval_q);
	assign sts.rev_more  = (lo_q < idx_q);
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign element      = elem_q;
	assign position     = pos_q;
	assign last_of_perm = last_q;
	assign final_perm   = final_q;
	assign exhausted    = exh_q;

endmodule
`default_nettype wire

[design/lpg_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module lpg_ctrl import lpg_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	input  wire  restart,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	st_t state_q;
	st_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		cmd.op      = OP_NONE;
		cmd.restart = restart;
		in_ready    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					// restart clears exhaustion before the check
					state_d = (sts.done && !restart) ? ST_EXH : ST_SCAN;
				end
			end
			ST_EXH: begin
				if (sts.out_free) begin
					cmd.op  = OP_EXH;
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				cmd.op = OP_SCAN;
				if (sts.scan_end)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.op = OP_EMIT;
					if (sts.emit_last)
						state_d = sts.found ? ST_FIND : ST_IDLE;
				end
			end
			ST_FIND: begin
				cmd.op = OP_FIND;
				if (sts.find_hit)
					state_d = ST_SWAP_I;
			end
			ST_SWAP_I: begin
				cmd.op  = OP_SWAP_I;
				state_d = ST_SWAP_J;
			end
			ST_SWAP_J: begin
				cmd.op  = OP_SWAP_J;
				state_d = ST_REV_RD;
			end
			ST_REV_RD: begin
				if (sts.rev_more) begin
					cmd.op  = OP_REV_RD;
					state_d = ST_REV_LO;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_REV_LO: begin
				cmd.op  = OP_REV_LO;
				state_d = ST_REV_HI;
			end
			ST_REV_HI: begin
				cmd.op  = OP_REV_HI;
				state_d = ST_REV_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

[design/lexicographic_permutation_generator.sv]
// Output: the first word follows the pivot scan after accept, then one word per cycle while out_ready is high.
// Requests: a new one is taken only once the previous one is done; the rate is bounded by the
//   one-port walk over the stored permutation.
// Exhausted requests give one word.
// Reset (arst_n, async, active low): length 3, identity permutation, not exhausted, no word out.
`timescale 1ns / 1ps
`default_nettype none
module lexicographic_permutation_generator import lpg_pkg::*; #(
	parameter int MAX_LENGTH = 8
) (
	input  wire               clk,
	input  wire               arst_n,
	// length register
	input  wire               cfg_we,
	input  wire [CFG_W-1:0]   cfg_wdata,
	// request channel
	input  wire               in_valid,
	output logic              in_ready,
	input  wire               restart,
	// element channel
	output logic              out_valid,
	input  wire               out_ready,
	output logic [ELEM_W-1:0] element,
	output logic [POS_W-1:0]  position,
	output logic              last_of_perm,
	output logic              final_perm,
	output logic              exhausted
);

	// The controller sequences each request:
	//   scan    - walk right to left for the pivot (first ascent); its absence
	//             marks the last permutation, so final_perm is known up front
	//   emit    - one word per element from the unchanged stored permutation
	//   find    - walk right to left for the first element above the pivot
	//   swap    - exchange pivot and partner (two writes)
	//   reverse - mirror the suffix pair by pair: read, write low, write high
	// The datapath holds the permutation with one read and one write port.
	// A word waiting in the output register does not hold off the next request.

	cmd_t cmd;
	sts_t sts;

	lpg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.restart  (restart),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lpg_datapath #(
		.MAX_LENGTH (MAX_LENGTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.sts          (sts),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.element      (element),
		.position     (position),
		.last_of_perm (last_of_perm),
		.final_perm   (final_perm),
		.exhausted    (exhausted)
	);

endmodule
`default_nettype wire

[design/lpg_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "lexicographic_permutation_generator_macros.svh"
module lpg_checker import lpg_pkg::*; (
	input wire              clk,
	input wire              arst_n,
	input wire              in_valid,
	input wire              in_ready,
	input wire              out_valid,
	input wire              out_ready,
	input wire [ELEM_W-1:0] element,
	input wire [POS_W-1:0]  position,
	input wire              last_of_perm,
	input wire              final_perm,
	input wire              exhausted
);

	// stalled word holds
	`LPG_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(element) && $stable(position) && $stable(exhausted), "output word changed while stalled")

	// exhausted word carries nothing
	`LPG_ASSERT(a_exh_form, out_valid && exhausted |-> element == '0 && position == '0 && !last_of_perm && !final_perm, "malformed exhausted word")

	// real elements are never zero
	`LPG_ASSERT(a_elem_nz, out_valid && !exhausted |-> element != '0, "zero element in permutation")

	// positions step by one within a permutation
	`LPG_ASSERT(a_pos_step, out_valid && out_ready && !exhausted && !last_of_perm |=> !out_valid || position == POS_W'($past(position) + POS_W'(1)), "position skipped")

	// a taken request drops ready while it is worked on
	`LPG_ASSERT(a_in_once, in_valid && in_ready |=> !in_ready, "request accepted twice")

endmodule

bind lexicographic_permutation_generator lpg_checker u_lpg_checker (.*);
`default_nettype wire
